>>> hdl/lmt_pkg.sv
// shared types, constants and a width helper for the line maximum tree
`default_nettype none

package lmt_pkg;

    localparam int X_BITS_DEF         = 10;
    localparam int SLOPE_BITS_DEF     = 32;
    localparam int INTERCEPT_BITS_DEF = 48;
    localparam int BEST_W             = 50;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MUL,
        S_SUM,
        S_DECIDE,
        S_FIN
    } state_t;

    // width of (sa - sb) * x + (ca - cb)
    function automatic int val_width(input int xb, input int sb, input int ib);
        int pw;
        int cw;
        pw = sb + 1 + xb;
        cw = ib + 1;
        return ((pw > cw) ? pw : cw) + 1;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lmt_eval.sv
// shared line difference evaluator: (sa - sb) * x + (ca - cb), three register stages
`default_nettype none

module lmt_eval #(
    parameter int X_BITS         = lmt_pkg::X_BITS_DEF,
    parameter int SLOPE_BITS     = lmt_pkg::SLOPE_BITS_DEF,
    parameter int INTERCEPT_BITS = lmt_pkg::INTERCEPT_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic signed [SLOPE_BITS-1:0]          a_slope,
    input  wire logic signed [SLOPE_BITS-1:0]          b_slope,
    input  wire logic signed [INTERCEPT_BITS-1:0]      a_icpt,
    input  wire logic signed [INTERCEPT_BITS-1:0]      b_icpt,
    input  wire logic signed [X_BITS-1:0]              xp,
    output logic signed [lmt_pkg::val_width(X_BITS, SLOPE_BITS, INTERCEPT_BITS)-1:0] result
);
    import lmt_pkg::*;

    localparam int DS_W   = SLOPE_BITS + 1;
    localparam int DC_W   = INTERCEPT_BITS + 1;
    localparam int PROD_W = DS_W + X_BITS;
    localparam int VAL_W  = val_width(X_BITS, SLOPE_BITS, INTERCEPT_BITS);

    logic signed [DS_W-1:0]   ds_reg;
    logic signed [DC_W-1:0]   dc_reg;
    logic signed [DC_W-1:0]   dc2_reg;
    logic signed [X_BITS-1:0] xp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  sum_reg;

    always_ff @(posedge aclk) begin
        ds_reg   <= DS_W'(a_slope) - DS_W'(b_slope);
        dc_reg   <= DC_W'(a_icpt) - DC_W'(b_icpt);
        xp_reg   <= xp;
        prod_reg <= ds_reg * xp_reg;
        dc2_reg  <= dc_reg;
        sum_reg  <= VAL_W'(prod_reg) + VAL_W'(dc2_reg);
    end

    assign result = sum_reg;

endmodule

`default_nettype wire

>>> hdl/lmt_node_ram.sv
// simple dual port node memory (one write port, one read port) with registered read
`default_nettype none

module lmt_node_ram #(
    parameter int ADDR_W = lmt_pkg::X_BITS_DEF + 1,
    parameter int DATA_W = 1 + lmt_pkg::SLOPE_BITS_DEF + lmt_pkg::INTERCEPT_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/line_max_tree_unit.sv
// top level: line maximum tree with node sequencer, node memory and shared evaluator
//
//  channel  | ports                                       | direction
//  ---------+---------------------------------------------+----------
//  input    | s_valid s_ready s_cmd s_x s_slope s_intercept | in
//  result   | m_valid m_ready m_best_value m_found        | out
//
// each tree level visited steps through node read, evaluator issue, two
// evaluator stages and decide/write; an item visits at most X_BITS+1 levels
// after reset every node memory word is cleared while s_ready is low
// one item at a time; a finished query result waits in the output register
// while the next item is taken, and a later query holds until it is free
`default_nettype none

module line_max_tree_unit #(
    parameter int X_BITS         = lmt_pkg::X_BITS_DEF,
    parameter int SLOPE_BITS     = lmt_pkg::SLOPE_BITS_DEF,
    parameter int INTERCEPT_BITS = lmt_pkg::INTERCEPT_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_cmd,
    input  wire logic signed [X_BITS-1:0]         s_x,
    input  wire logic signed [SLOPE_BITS-1:0]     s_slope,
    input  wire logic signed [INTERCEPT_BITS-1:0] s_intercept,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [lmt_pkg::BEST_W-1:0]     m_best_value,
    output logic                                  m_found
);
    import lmt_pkg::*;

    localparam int IDX_W  = X_BITS + 1;
    localparam int LVL_W  = $clog2(X_BITS + 1);
    localparam int VAL_W  = val_width(X_BITS, SLOPE_BITS, INTERCEPT_BITS);
    localparam int WORD_W = 1 + SLOPE_BITS + INTERCEPT_BITS;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]                 clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [LVL_W-1:0]                 lvl_reg, lvl_next;
    logic signed [X_BITS-1:0]         lo_reg, lo_next;
    logic                             cmd_reg, cmd_next;
    logic signed [X_BITS-1:0]         x_reg, x_next;
    logic signed [SLOPE_BITS-1:0]     car_s_reg, car_s_next;
    logic signed [INTERCEPT_BITS-1:0] car_c_reg, car_c_next;
    logic signed [VAL_W-1:0]          best_reg, best_next;
    logic                             found_reg, found_next;
    logic                             out_valid_reg, out_valid_next;
    logic signed [BEST_W-1:0]         out_best_reg, out_best_next;
    logic                             out_found_reg, out_found_next;

    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [WORD_W-1:0]                wr_data;
    logic                             rd_en;
    logic [WORD_W-1:0]                rd_word;

    logic                             n_valid;
    logic signed [SLOPE_BITS-1:0]     n_s;
    logic signed [INTERCEPT_BITS-1:0] n_c;
    logic                             is_leaf;
    logic                             steeper;
    logic signed [SLOPE_BITS-1:0]     k_s, c_s;
    logic signed [INTERCEPT_BITS-1:0] k_c, c_c;
    logic [X_BITS:0]                  half;
    logic [X_BITS:0]                  mid_w;
    logic signed [X_BITS-1:0]         mid;
    logic                             x_lt_mid;
    logic [IDX_W-1:0]                 idx_lo, idx_hi;

    logic signed [SLOPE_BITS-1:0]     ev_a_s, ev_b_s;
    logic signed [INTERCEPT_BITS-1:0] ev_a_c, ev_b_c;
    logic signed [X_BITS-1:0]         ev_x;
    logic signed [VAL_W-1:0]          ev_res;
    logic [BEST_W+VAL_W-1:0]          best_ext;
    logic                             out_load;

    lmt_node_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_word)
    );

    lmt_eval #(
        .X_BITS         (X_BITS),
        .SLOPE_BITS     (SLOPE_BITS),
        .INTERCEPT_BITS (INTERCEPT_BITS)
    ) u_eval (
        .aclk    (aclk),
        .a_slope (ev_a_s),
        .b_slope (ev_b_s),
        .a_icpt  (ev_a_c),
        .b_icpt  (ev_b_c),
        .xp      (ev_x),
        .result  (ev_res)
    );

    // node decode and keep/carry selection
    always_comb begin
        n_valid  = rd_word[WORD_W-1];
        n_s      = $signed(rd_word[SLOPE_BITS+INTERCEPT_BITS-1:INTERCEPT_BITS]);
        n_c      = $signed(rd_word[INTERCEPT_BITS-1:0]);
        is_leaf  = (lvl_reg == LVL_W'(X_BITS));
        steeper  = (n_s < car_s_reg);
        k_s      = steeper ? car_s_reg : n_s;
        k_c      = steeper ? car_c_reg : n_c;
        c_s      = steeper ? n_s : car_s_reg;
        c_c      = steeper ? n_c : car_c_reg;
        half     = ({1'b1, {X_BITS{1'b0}}} >> lvl_reg) >> 1;
        mid_w    = {lo_reg[X_BITS-1], lo_reg} + half;
        mid      = $signed(mid_w[X_BITS-1:0]);
        x_lt_mid = (x_reg < mid);
        idx_lo   = {idx_reg[IDX_W-2:0], 1'b0};
        idx_hi   = {idx_reg[IDX_W-2:0], 1'b1};
    end

    // evaluator operands
    always_comb begin
        ev_a_s = n_s;
        ev_b_s = '0;
        ev_a_c = n_c;
        ev_b_c = '0;
        ev_x   = x_reg;
        if (cmd_reg == CMD_INSERT) begin
            if (is_leaf) begin
                ev_a_s = car_s_reg;
                ev_a_c = car_c_reg;
                ev_b_s = n_s;
                ev_b_c = n_c;
                ev_x   = lo_reg;
            end else begin
                ev_a_s = c_s;
                ev_a_c = c_c;
                ev_b_s = k_s;
                ev_b_c = k_c;
                ev_x   = mid;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_idx_reg == {IDX_W{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!n_valid) begin
                    state_next = (cmd_reg == CMD_QUERY) ? S_FIN : S_IDLE;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_SUM;
            end
            S_SUM: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (is_leaf) begin
                    state_next = (cmd_reg == CMD_QUERY) ? S_FIN : S_IDLE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        clr_idx_next = clr_idx_reg;
        idx_next     = idx_reg;
        lvl_next     = lvl_reg;
        lo_next      = lo_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        car_s_next   = car_s_reg;
        car_c_next   = car_c_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = {1'b1, car_s_reg, car_c_reg};
        rd_en        = 1'b0;
        s_ready      = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    x_next     = s_x;
                    car_s_next = s_slope;
                    car_c_next = s_intercept;
                    idx_next   = IDX_W'(1);
                    lvl_next   = '0;
                    lo_next    = {1'b1, {(X_BITS-1){1'b0}}};
                    best_next  = '0;
                    found_next = 1'b0;
                end
            end
            S_READ: begin
                rd_en = 1'b1;
            end
            S_EVAL: begin
                if (!n_valid && cmd_reg == CMD_INSERT) begin
                    wr_en = 1'b1;
                end
            end
            S_DECIDE: begin
                if (cmd_reg == CMD_QUERY) begin
                    if (!found_reg || ev_res > best_reg) begin
                        best_next = ev_res;
                    end
                    found_next = 1'b1;
                    if (!x_lt_mid) begin
                        lo_next  = mid;
                        idx_next = idx_hi;
                    end else begin
                        idx_next = idx_lo;
                    end
                end else if (is_leaf) begin
                    if (!ev_res[VAL_W-1] && ev_res != '0) begin
                        wr_en = 1'b1;
                    end
                end else begin
                    wr_en = 1'b1;
                    if (!ev_res[VAL_W-1]) begin
                        // shallower line wins or ties at the midpoint and stays, steeper goes up
                        wr_data    = {1'b1, c_s, c_c};
                        car_s_next = k_s;
                        car_c_next = k_c;
                        lo_next    = mid;
                        idx_next   = idx_hi;
                    end else begin
                        wr_data    = {1'b1, k_s, k_c};
                        car_s_next = c_s;
                        car_c_next = c_c;
                        idx_next   = idx_lo;
                    end
                end
                lvl_next = lvl_reg + 1'b1;
            end
            S_FIN: begin
                out_load = !out_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        best_ext       = {{BEST_W{best_reg[VAL_W-1]}}, best_reg};
        out_valid_next = out_valid_reg && !m_ready;
        out_best_next  = out_best_reg;
        out_found_next = out_found_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_best_next  = $signed(best_ext[BEST_W-1:0]);
            out_found_next = found_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        lvl_reg       <= lvl_next;
        lo_reg        <= lo_next;
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        car_s_reg     <= car_s_next;
        car_c_reg     <= car_c_next;
        best_reg      <= best_next;
        found_reg     <= found_next;
        out_best_reg  <= out_best_next;
        out_found_reg <= out_found_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_best_value = out_best_reg;
    assign m_found      = out_found_reg;

endmodule

`default_nettype wire
